>>> rtl/core/overlapping_fragment_splitter_assert.svh
// Assertion macros used by the fragment splitter RTL.
`ifndef OVERLAPPING_FRAGMENT_SPLITTER_ASSERT_SVH
`define OVERLAPPING_FRAGMENT_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OFS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ofs_pkg.sv
// Package with types and constants of the overlapping fragment splitter.
package ofs_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned MAX_PIECES = 64;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned PIECE_W    = $clog2(MAX_PIECES + 1);
  localparam int unsigned STEP_W     = $clog2(CFG_W);

  localparam logic [3:0] N_CODE = 4'hF;

  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_END   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPLIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP   = 1'd1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_W-1:0]      word_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] entry_position;
    logic [31:0] run_len;
    logic [3:0]  base_code;
    logic [31:0] seq_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frag_first;
    logic [31:0] frag_last;
    logic        last_of_run;
    logic        sequence_done;
    logic        split_capped;
  } out_item_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

endpackage

>>> rtl/core/ofs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ofs_div import ofs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  word_t             rem_q, rem_d;
  word_t             quo_q, quo_d;
  word_t             dvs_q, dvs_d;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;

  always_comb begin
    trial  = {rem_q, quo_q[CFG_W-1]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[CFG_W]) begin
        rem_d = diff[CFG_W-1:0];
      end else begin
        rem_d = trial[CFG_W-1:0];
      end
      quo_d = {quo_q[CFG_W-2:0], !diff[CFG_W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(CFG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/core/overlapping_fragment_splitter.sv
// Top level of the overlapping fragment splitter.
// A split segment runs through two serial divisions on one shared divider before its first
// beat, then gives one piece per cycle while the output is not stalled.
// A whole fragment comes without a division, or after the first division when it gives no
// piece; the input is ready again in the cycle after the last beat, at once without one.
// Reset clears the two configuration registers to zero, the cursor to one and the output beat.
module overlapping_fragment_splitter import ofs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  word_t                cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_DIV1   = 3'd2;
  localparam logic [2:0] S_NSET   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIV2   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;
  localparam logic [2:0] S_SINGLE = 3'd7;

  logic [2:0]         state_q, state_d;
  word_t              msl_q, msl_d;
  word_t              ov_q, ov_d;
  coord_t             cursor_q, cursor_d;
  logic               frag_q, frag_d;
  logic               done_q, done_d;
  coord_t             seg_s_q, seg_s_d;
  coord_t             seg_e_q, seg_e_d;
  coord_t             len_q, len_d;
  logic [PIECE_W-1:0] n_q, n_d;
  logic               capped_q, capped_d;
  coord_t             q_q, q_d;
  logic [PIECE_W-1:0] r_q, r_d;
  logic [PIECE_W-1:0] idx_q, idx_d;
  coord_t             pos_q, pos_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                       in_acc;
  logic                       out_free;
  coord_t                     epos, run, parent, ns, ne, nxt;
  coord_t                     len, ov_c, uniq, plen, fs, fe;
  logic [PIECE_W-1:0]         nm1;
  logic [CFG_W+PIECE_W-1:0]   prod_full;
  logic                       last;

  ofs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    epos      = in_data_i.entry_position[COORD_BITS-1:0];
    run       = in_data_i.run_len[COORD_BITS-1:0];
    parent    = in_data_i.seq_length[COORD_BITS-1:0];
    ns        = epos + 1'b1;
    ne        = epos + run;
    nxt       = ne + 1'b1;
    ov_c      = ov_q[COORD_BITS-1:0];
    len       = seg_e_q - seg_s_q + 1'b1;
    nm1       = n_q - 1'b1;
    prod_full = (CFG_W + PIECE_W)'(ov_q) * (CFG_W + PIECE_W)'(nm1);
    uniq      = len_q - prod_full[COORD_BITS-1:0];
    last      = (PIECE_W'(idx_q + 1'b1) == n_q);
    plen      = q_q + coord_t'(idx_q < r_q) + (last ? coord_t'(0) : ov_c);
    fs        = seg_s_q + pos_q;
    fe        = fs + plen - 1'b1;

    state_d     = state_q;
    msl_d       = msl_q;
    ov_d        = ov_q;
    cursor_d    = cursor_q;
    frag_d      = frag_q;
    done_d      = done_q;
    seg_s_d     = seg_s_q;
    seg_e_d     = seg_e_q;
    len_d       = len_q;
    n_d         = n_q;
    capped_d    = capped_q;
    q_d         = q_q;
    r_d         = r_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    div_req     = '0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIN_SPLIT: msl_d = cfg_wdata_i;
        REG_OVERLAP:   ov_d  = cfg_wdata_i;
        default:       msl_d = msl_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OP_END) begin
            done_d   = 1'b1;
            cursor_d = coord_t'(1);
            frag_d   = 1'b0;
            if (parent != '0) begin
              if (msl_q == '0) begin
                seg_s_d = coord_t'(1);
                seg_e_d = parent;
                state_d = S_SINGLE;
              end else if (cursor_q <= parent) begin
                seg_s_d = cursor_q;
                seg_e_d = parent;
                state_d = S_PREP;
              end else if (!frag_q) begin
                seg_s_d = coord_t'(1);
                seg_e_d = parent;
                state_d = S_SINGLE;
              end
            end
          end else if (msl_q != '0 && in_data_i.base_code == N_CODE) begin
            done_d = 1'b0;
            if (ns > cursor_q) begin
              seg_s_d = cursor_q;
              seg_e_d = ns - 1'b1;
              frag_d  = 1'b1;
              state_d = S_PREP;
            end
            if (nxt > cursor_q) begin
              cursor_d = nxt;
            end
          end
        end
      end
      S_PREP: begin
        len_d = len;
        if (word_t'(len) > ov_q && msl_q > ov_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = word_t'(len) - ov_q;
          div_req.divisor  = msl_q - ov_q;
          state_d          = S_DIV1;
        end else begin
          state_d = S_SINGLE;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_d = S_NSET;
        end
      end
      S_NSET: begin
        if (div_rsp.quotient == '0) begin
          state_d = S_SINGLE;
        end else begin
          if (div_rsp.quotient > word_t'(MAX_PIECES)) begin
            n_d      = PIECE_W'(MAX_PIECES);
            capped_d = 1'b1;
          end else begin
            n_d      = div_rsp.quotient[PIECE_W-1:0];
            capped_d = 1'b0;
          end
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = word_t'(uniq);
        div_req.divisor  = word_t'(n_q);
        state_d          = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          q_d     = div_rsp.quotient[COORD_BITS-1:0];
          r_d     = div_rsp.remainder[PIECE_W-1:0];
          idx_d   = '0;
          pos_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.frag_first    = 32'(fs);
          out_d.frag_last     = 32'(fe);
          out_d.last_of_run   = last;
          out_d.sequence_done = last && done_q;
          out_d.split_capped  = capped_q;
          pos_d               = pos_q + plen - ov_c;
          idx_d               = idx_q + 1'b1;
          if (last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.frag_first    = 32'(seg_s_q);
          out_d.frag_last     = 32'(seg_e_q);
          out_d.last_of_run   = 1'b1;
          out_d.sequence_done = done_q;
          out_d.split_capped  = 1'b0;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      msl_q       <= '0;
      ov_q        <= '0;
      cursor_q    <= coord_t'(1);
      frag_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      msl_q       <= msl_d;
      ov_q        <= ov_d;
      cursor_q    <= cursor_d;
      frag_q      <= frag_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_s_q  <= seg_s_d;
    seg_e_q  <= seg_e_d;
    len_q    <= len_d;
    n_q      <= n_d;
    capped_q <= capped_d;
    q_q      <= q_d;
    r_q      <= r_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    out_q    <= out_d;
  end

`include "overlapping_fragment_splitter_assert.svh"

  `OFS_ASSERT_IMPLIES(a_done_is_last, out_valid_o && out_data_o.sequence_done,
    out_data_o.last_of_run, "Sequence end beat is not the last beat of its item.")
  `OFS_ASSERT_IMPLIES(a_emit_index, state_q == S_EMIT, idx_q < n_q,
    "Piece index ran past the piece count.")
  `OFS_ASSERT_IMPLIES(a_capped_full, state_q == S_EMIT && capped_q,
    n_q == PIECE_W'(MAX_PIECES), "Capped segment does not use the full piece count.")
  `OFS_ASSERT_NEXT(a_end_clears, in_valid_i && in_ready_o && in_data_i.opcode == OP_END,
    cursor_q == coord_t'(1) && !frag_q, "End beat did not clear the sequence state.")

endmodule

>>> test/overlapping_fragment_splitter_test.sv
// Self-checking testbench of the overlapping fragment splitter.
`timescale 1ns / 1ps

module overlapping_fragment_splitter_test import ofs_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS  = 34;
  localparam int unsigned NUM_PHASES   = 9;

  class fragment_tracker;
    word_t       min_split;
    word_t       overlap;
    coord_t      cursor;
    bit          emitted;
    out_item_t   expected_frags[$];
    out_item_t   batch[$];
    int unsigned errors;

    function new();
      min_split = '0;
      overlap   = '0;
      cursor    = 1;
      emitted   = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
      if (idx == REG_MIN_SPLIT) begin
        min_split = value;
      end else if (idx == REG_OVERLAP) begin
        overlap = value;
      end
    endfunction

    function void add_frag(coord_t first, coord_t last, bit capped);
      out_item_t frag;
      frag.frag_first    = first;
      frag.frag_last     = last;
      frag.last_of_run   = 1'b0;
      frag.sequence_done = 1'b0;
      frag.split_capped  = capped;
      batch = {batch, frag};
    endfunction

    function void cut_segment(coord_t first, coord_t last);
      coord_t      len;
      coord_t      pieces;
      coord_t      uniq;
      coord_t      quot;
      coord_t      rem;
      coord_t      pos;
      coord_t      plen;
      coord_t      fs;
      bit          capped;
      int unsigned i;
      len    = last - first + 1;
      pieces = 0;
      capped = 1'b0;
      if (len > overlap && min_split > overlap) begin
        pieces = (len - overlap) / (min_split - overlap);
      end
      if (pieces == 0) begin
        add_frag(first, last, 1'b0);
        return;
      end
      if (pieces > MAX_PIECES) begin
        pieces = MAX_PIECES;
        capped = 1'b1;
      end
      uniq = len - (pieces - 1) * overlap;
      quot = uniq / pieces;
      rem  = uniq % pieces;
      pos  = 0;
      for (i = 0; i < pieces; i++) begin
        plen = quot + ((i < rem) ? 1 : 0);
        if (i + 1 != pieces) begin
          plen = plen + overlap;
        end
        fs = first + pos;
        add_frag(fs, fs + plen - 1, capped);
        pos = pos + plen - overlap;
      end
    endfunction

    function void predict_fragments(in_item_t item);
      coord_t run_first;
      coord_t run_last;
      coord_t next_cursor;
      batch.delete();
      if (item.opcode == OP_ENTRY) begin
        if (min_split != 0 && item.base_code == N_CODE) begin
          run_first = item.entry_position + 1;
          run_last  = item.entry_position + item.run_len;
          if (run_first > cursor) begin
            cut_segment(cursor, run_first - 1);
          end
          next_cursor = run_last + 1;
          if (next_cursor > cursor) begin
            cursor = next_cursor;
          end
          if (batch.size() > 0) begin
            emitted = 1'b1;
          end
        end
      end else begin
        if (item.seq_length != 0) begin
          if (min_split == 0) begin
            add_frag(1, item.seq_length, 1'b0);
          end else begin
            if (cursor <= item.seq_length) begin
              cut_segment(cursor, item.seq_length);
            end
            if (batch.size() == 0 && !emitted) begin
              add_frag(1, item.seq_length, 1'b0);
            end
          end
          if (batch.size() > 0) begin
            batch[$].sequence_done = 1'b1;
          end
        end
        cursor  = 1;
        emitted = 1'b0;
      end
      if (batch.size() > 0) begin
        batch[$].last_of_run = 1'b1;
      end
      foreach (batch[k]) begin
        expected_frags = {expected_frags, batch[k]};
      end
    endfunction

    function int unsigned field_diff(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, actual %0d", name, want, seen);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_frags.size() == 0) begin
        $error("fragment beat %0d..%0d arrived with no fragment expected",
               got.frag_first, got.frag_last);
        errors++;
        return;
      end
      want = expected_frags.pop_front();
      errors += field_diff("frag_first", want.frag_first, got.frag_first);
      errors += field_diff("frag_last", want.frag_last, got.frag_last);
      errors += field_diff("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      errors += field_diff("sequence_done", 32'(want.sequence_done),
                           32'(got.sequence_done));
      errors += field_diff("split_capped", 32'(want.split_capped), 32'(got.split_capped));
    endfunction

    function int unsigned pending();
      return expected_frags.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  word_t                cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;

  fragment_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned sent_beats  = 0;
  int unsigned ready_left  = 0;
  int unsigned ready_mode  = 0;

  overlapping_fragment_splitter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("overlapping_fragment_splitter_test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result(out_data_o);
    end
  end

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = (ready_mode == 1) ? $urandom_range(1, 6) : $urandom_range(1, 40);
    end
    ready_left--;
    case (ready_mode)
      0: begin
        out_ready_i = 1'b1;
      end
      1: begin
        out_ready_i = 1'b0;
      end
      default: begin
        out_ready_i = 1'($urandom_range(0, 1));
      end
    endcase
  end

  function automatic in_item_t make_entry(coord_t pos, coord_t run, logic [3:0] code);
    in_item_t item;
    item.opcode         = OP_ENTRY;
    item.entry_position = pos;
    item.run_len        = run;
    item.base_code      = code;
    item.seq_length     = $urandom;
    return item;
  endfunction

  function automatic in_item_t make_end(coord_t parent);
    in_item_t item;
    item.opcode         = OP_END;
    item.entry_position = $urandom;
    item.run_len        = $urandom;
    item.base_code      = 4'($urandom_range(0, 15));
    item.seq_length     = parent;
    return item;
  endfunction

  // Called and left at a falling edge; valid stays high across a burst.
  task automatic push_item(in_item_t item);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_data_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.predict_fragments(item);
    sent_beats++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_regs(word_t min_len, word_t ov_len);
    cfg_we_i    = 1'b1;
    cfg_index_i = REG_MIN_SPLIT;
    cfg_wdata_i = min_len;
    tracker.write_reg(REG_MIN_SPLIT, min_len);
    @(negedge clk_i);
    cfg_index_i = REG_OVERLAP;
    cfg_wdata_i = ov_len;
    tracker.write_reg(REG_OVERLAP, ov_len);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_random(int unsigned target);
    in_item_t    item;
    coord_t      parent;
    coord_t      pos;
    int unsigned entries;
    int unsigned pick;
    int unsigned j;
    sent_beats = 0;
    while (sent_beats < target) begin
      if ($urandom_range(0, 99) < 15) begin
        item.opcode         = 1'($urandom_range(0, 1));
        item.entry_position = $urandom;
        item.run_len        = $urandom;
        item.base_code      = 4'($urandom_range(0, 15));
        item.seq_length     = $urandom;
        push_item(item);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          parent = 0;
        end else if (pick < 15) begin
          parent = $urandom;
        end else begin
          parent = $urandom_range(1, 400);
        end
        entries = $urandom_range(0, 5);
        pos     = $urandom_range(0, 40);
        for (j = 0; j < entries; j++) begin
          item = make_entry(pos,
                            ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12),
                            ($urandom_range(0, 99) < 85) ? N_CODE :
                                                           4'($urandom_range(0, 14)));
          push_item(item);
          pos = pos + item.run_len + $urandom_range(0, 120);
        end
        push_item(make_end(parent));
      end
    end
  endtask

  initial begin
    word_t       msl_set[NUM_PHASES];
    word_t       ov_set[NUM_PHASES];
    int unsigned p;
    msl_set[0] = 0;             ov_set[0] = 0;
    msl_set[1] = 16;            ov_set[1] = 4;
    msl_set[2] = 1;             ov_set[2] = 0;
    msl_set[3] = 11;            ov_set[3] = 10;
    msl_set[4] = 7;             ov_set[4] = 9;
    msl_set[5] = $urandom_range(2, 200);
    ov_set[5]  = $urandom_range(0, msl_set[5] - 1);
    msl_set[6] = 32'hFFFF_FFFF; ov_set[6] = 32'hFFFF_FFFF;
    msl_set[7] = 32'hFFFF_FFFF; ov_set[7] = 0;
    msl_set[8] = $urandom;      ov_set[8] = $urandom;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    push_item(make_entry(10, 5, N_CODE));
    push_item(make_end(100));
    push_item(make_end(0));
    push_item(make_end(32'hFFFF_FFFF));
    settle();

    program_regs(10, 2);
    push_item(make_entry(20, 3, 4'h3));
    push_item(make_entry(0, 3, N_CODE));
    push_item(make_entry(40, 5, N_CODE));
    push_item(make_entry(41, 0, N_CODE));
    push_item(make_end(100));
    push_item(make_entry(0, 100, N_CODE));
    push_item(make_end(50));
    push_item(make_entry(20, 100, N_CODE));
    push_item(make_end(60));
    push_item(make_entry(30, 4, N_CODE));
    push_item(make_end(0));
    push_item(make_end(32'hFFFF_FFFF));
    push_item(make_entry(32'hFFFF_FFFF, 2, N_CODE));
    push_item(make_end(10));
    settle();

    program_regs(5, 5);
    push_item(make_end(30));
    settle();
    program_regs(3, 7);
    push_item(make_end(30));
    settle();
    program_regs(11, 10);
    push_item(make_end(50));
    settle();
    program_regs(1, 0);
    push_item(make_end(200));
    settle();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(make_end(32'hFFFF_FFFF));
    settle();
    program_regs(32'hFFFF_FFFF, 0);
    push_item(make_end(32'hFFFF_FFFF));
    settle();

    for (p = 0; p < NUM_PHASES; p++) begin
      program_regs(msl_set[p], ov_set[p]);
      run_random(PHASE_ITEMS);
      settle();
    end

    if (tracker.errors == 0) begin
      $display("overlapping_fragment_splitter_test passed");
    end else begin
      $display("overlapping_fragment_splitter_test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ofs_pkg.sv
rtl/core/ofs_div.sv
rtl/core/overlapping_fragment_splitter.sv
test/overlapping_fragment_splitter_test.sv
